FILE: rtl/rcss_pkg.sv
// ----------------------------------------------------------------------------
// rcss_pkg
// Types, constants and codes shared by the ready-channel streak scheduler.
// ----------------------------------------------------------------------------
package rcss_pkg;

  localparam int NCH          = 16;
  localparam int STREAK_LIMIT = 1024;
  // only the first sixteen channels can carry a member bit
  localparam int LIVE_CH      = (NCH < 16) ? NCH : 16;
  localparam int STREAK_W     = $clog2(STREAK_LIMIT + 1);
  localparam int QA_W         = (LIVE_CH > 1) ? $clog2(LIVE_CH) : 1;

  localparam int MASK_W     = 16;
  localparam int CAP_W      = 8;
  localparam int CH_W       = 4;
  localparam int QCNT_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CAP_W-1:0] READ_CAP_RST = 8'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_MEMBER_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_CAP    = 2'd1;

  localparam logic OP_POLL = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  typedef enum logic [2:0] {
    ST_POLLED     = 3'd0,
    ST_POLL_SKIP  = 3'd1,
    ST_NONE_READY = 3'd2,
    ST_GRANTED    = 3'd3,
    ST_NOT_POLLED = 3'd4,
    ST_EMPTY      = 3'd5,
    ST_CAP        = 3'd6
  } status_t;

  typedef struct packed {
    logic              op;
    logic [MASK_W-1:0] ready_mask;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [CH_W-1:0]   channel;
    logic [QCNT_W-1:0] queued_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    upd;
    logic    rank;
    logic    finish;
    logic    pop;
    logic    flush;
    logic    clr_polled;
    logic    emit;
    status_t code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic poll_skip;
    logic none_ready;
    logic not_polled;
    logic q_empty;
    logic cap_hit;
    logic rank_last;
  } sts_t;

endpackage

FILE: rtl/rcss_datapath.sv
// ----------------------------------------------------------------------------
// rcss_datapath
// Streak counters, service queue, pop counter, config registers and the
// result register, driven step by step by the controller.
// ----------------------------------------------------------------------------
module rcss_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [rcss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcss_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [rcss_pkg::MASK_W-1:0]        in_mask,
  input  rcss_pkg::cmd_t                     cmd,
  output rcss_pkg::sts_t                     sts,
  output logic                               out_strobe,
  output rcss_pkg::out_item_t                out_item
);

  logic [rcss_pkg::MASK_W-1:0]   member_r;
  logic [rcss_pkg::CAP_W-1:0]    cap_r;
  logic [rcss_pkg::STREAK_W-1:0] streak_r [rcss_pkg::LIVE_CH];
  logic [rcss_pkg::CH_W-1:0]     queue_r  [rcss_pkg::LIVE_CH];
  logic [rcss_pkg::QA_W-1:0]     head_r, head_nxt;
  logic [rcss_pkg::QCNT_W-1:0]   len_r, len_nxt;
  logic                          polled_r, polled_nxt;
  logic [rcss_pkg::CAP_W-1:0]    reads_r, reads_nxt;
  logic [rcss_pkg::LIVE_CH-1:0]  rdy_r;
  logic [rcss_pkg::QA_W-1:0]     idx_r;
  logic [rcss_pkg::QCNT_W-1:0]   cnt_r;
  logic                          out_vld_r;
  rcss_pkg::out_item_t           out_r;

  logic [rcss_pkg::STREAK_W-1:0] key;
  logic [rcss_pkg::QA_W-1:0]     rank;
  logic [rcss_pkg::CH_W-1:0]     head_ch;

  assign key     = streak_r[idx_r];
  assign head_ch = queue_r[head_r];

  // position of the current channel: ready channels with a smaller streak,
  // or an equal streak and a lower index
  always_comb begin
    rank = '0;
    for (int j = 0; j < rcss_pkg::LIVE_CH; j++) begin
      if (rdy_r[j] && ((streak_r[j] < key) ||
                       ((streak_r[j] == key) && (rcss_pkg::QA_W'(j) < idx_r)))) begin
        rank = rank + rcss_pkg::QA_W'(1);
      end
    end
  end

  assign sts.poll_skip  = polled_r && (len_r != '0);
  assign sts.none_ready = (rdy_r == '0);
  assign sts.not_polled = !polled_r;
  assign sts.q_empty    = (len_r == '0);
  assign sts.cap_hit    = (reads_r > cap_r);
  assign sts.rank_last  = (idx_r == rcss_pkg::QA_W'(rcss_pkg::LIVE_CH - 1));

  always_comb begin
    head_nxt   = head_r;
    len_nxt    = len_r;
    polled_nxt = polled_r;
    reads_nxt  = reads_r;
    if (cmd.clr_polled) begin
      polled_nxt = 1'b0;
    end
    if (cmd.flush) begin
      len_nxt    = '0;
      reads_nxt  = '0;
      polled_nxt = 1'b0;
    end
    if (cmd.pop) begin
      head_nxt = head_r + rcss_pkg::QA_W'(1);
      len_nxt  = len_r - rcss_pkg::QCNT_W'(1);
      if (reads_r != '1) begin
        reads_nxt = reads_r + rcss_pkg::CAP_W'(1);
      end
    end
    if (cmd.finish) begin
      len_nxt    = cnt_r + rcss_pkg::QCNT_W'(rdy_r[idx_r]);
      head_nxt   = '0;
      polled_nxt = 1'b1;
      reads_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      member_r  <= '0;
      cap_r     <= rcss_pkg::READ_CAP_RST;
      head_r    <= '0;
      len_r     <= '0;
      polled_r  <= 1'b0;
      reads_r   <= '0;
      idx_r     <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
      for (int j = 0; j < rcss_pkg::LIVE_CH; j++) begin
        streak_r[j] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rcss_pkg::CFG_MEMBER_MASK: member_r <= cfg_data[rcss_pkg::MASK_W-1:0];
          rcss_pkg::CFG_READ_CAP:    cap_r    <= cfg_data[rcss_pkg::CAP_W-1:0];
          default: ;
        endcase
      end
      head_r    <= head_nxt;
      len_r     <= len_nxt;
      polled_r  <= polled_nxt;
      reads_r   <= reads_nxt;
      out_vld_r <= cmd.emit;
      if (cmd.upd) begin
        idx_r <= '0;
        cnt_r <= '0;
        for (int j = 0; j < rcss_pkg::LIVE_CH; j++) begin
          if (member_r[j]) begin
            if (!rdy_r[j]) begin
              streak_r[j] <= '0;
            end else if (streak_r[j] == rcss_pkg::STREAK_W'(rcss_pkg::STREAK_LIMIT)) begin
              streak_r[j] <= rcss_pkg::STREAK_W'(1);
            end else begin
              streak_r[j] <= streak_r[j] + rcss_pkg::STREAK_W'(1);
            end
          end
        end
      end
      if (cmd.rank) begin
        idx_r <= idx_r + rcss_pkg::QA_W'(1);
        cnt_r <= cnt_r + rcss_pkg::QCNT_W'(rdy_r[idx_r]);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rdy_r <= in_mask[rcss_pkg::LIVE_CH-1:0] & member_r[rcss_pkg::LIVE_CH-1:0];
    end
    if (cmd.rank && rdy_r[idx_r]) begin
      queue_r[rank] <= rcss_pkg::CH_W'(idx_r);
    end
    if (cmd.emit) begin
      out_r.status       <= cmd.code;
      out_r.channel      <= cmd.pop ? head_ch : '0;
      out_r.queued_count <= len_nxt;
    end
  end

  assign out_strobe = out_vld_r;
  assign out_item   = out_r;

endmodule

FILE: rtl/rcss_ctrl.sv
// ----------------------------------------------------------------------------
// rcss_ctrl
// Sequencer: decodes an item, then either answers at once or walks the
// channels to rebuild the service queue.
// ----------------------------------------------------------------------------
module rcss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_op,
  input  rcss_pkg::sts_t     sts,
  output rcss_pkg::cmd_t     cmd,
  output logic               busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_RANK
  } state_t;

  state_t state_r, state_nxt;
  logic   op_r, op_nxt;

  always_comb begin
    cmd       = '0;
    cmd.code  = rcss_pkg::ST_POLLED;
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          op_nxt      = in_op;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        if (op_r == rcss_pkg::OP_POLL) begin
          if (sts.poll_skip) begin
            cmd.emit = 1'b1;
            cmd.code = rcss_pkg::ST_POLL_SKIP;
          end else if (sts.none_ready) begin
            cmd.clr_polled = 1'b1;
            cmd.emit       = 1'b1;
            cmd.code       = rcss_pkg::ST_NONE_READY;
          end else begin
            cmd.clr_polled = 1'b1;
            cmd.upd        = 1'b1;
            state_nxt      = S_RANK;
          end
        end else begin
          cmd.emit = 1'b1;
          if (sts.not_polled) begin
            cmd.code = rcss_pkg::ST_NOT_POLLED;
          end else if (sts.q_empty) begin
            cmd.clr_polled = 1'b1;
            cmd.code       = rcss_pkg::ST_EMPTY;
          end else if (sts.cap_hit) begin
            cmd.flush = 1'b1;
            cmd.code  = rcss_pkg::ST_CAP;
          end else begin
            cmd.pop  = 1'b1;
            cmd.code = rcss_pkg::ST_GRANTED;
          end
        end
      end
      S_RANK: begin
        cmd.rank = 1'b1;
        if (sts.rank_last) begin
          cmd.finish = 1'b1;
          cmd.emit   = 1'b1;
          cmd.code   = rcss_pkg::ST_POLLED;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= rcss_pkg::OP_POLL;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: rtl/ready_channel_streak_scheduler.sv
// ----------------------------------------------------------------------------
// ready_channel_streak_scheduler
// Orders ready channels by streak length and hands them out one at a time.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. op selects a poll
//   (ready_mask is ANDed with the member mask) or a request for the next
//   channel. Every item gives exactly one result on out_item, shown for one
//   cycle with out_strobe high; the receiver cannot hold it off.
//   Config: cfg_index/cfg_data written when cfg_valid is high (cfg_ready is
//   always high); index 0 is the member mask, index 1 the read cap. Write
//   only while busy is low and no result is still to come.
//   Sequence: a next request, or a poll that is skipped or finds no member
//   ready, is settled in the decide state and its result is then registered. A
//   poll that rebuilds the queue walks one channel per cycle through the
//   rank logic after the decide state and then registers its result.
//   busy falls in the cycle the result is shown, so the next item can be
//   accepted at the edge that ends it; a new item is not taken while the
//   last one is still in progress.
//   Reset (rst_n low, synchronous): streaks cleared, queue empty, not
//   polled, pop count zero, member mask zero, read cap 16.
// ----------------------------------------------------------------------------
module ready_channel_streak_scheduler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  rcss_pkg::in_item_t                 in_item,
  output logic                               out_strobe,
  output rcss_pkg::out_item_t                out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rcss_pkg::cmd_t cmd;
  rcss_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  rcss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_item.op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  rcss_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mask    (in_item.ready_mask),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

FILE: rtl/rcss_checker.sv
// ----------------------------------------------------------------------------
// rcss_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rcss_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_strobe,
  input rcss_pkg::out_item_t                out_item
);

  // an accepted item keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // one result per item, never two in a row
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // a result only follows work in progress
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!busy && $past(busy)))
    else $error("result without a preceding busy phase");

  // channel is zero unless granted
  a_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status != rcss_pkg::ST_GRANTED)) |-> (out_item.channel == '0))
    else $error("channel set on a non-grant result");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.queued_count <= rcss_pkg::QCNT_W'(rcss_pkg::LIVE_CH)))
    else $error("queued count out of range");

endmodule

bind ready_channel_streak_scheduler rcss_checker u_rcss_checker (.*);
